### hdl/dstx_pkg.sv
// ----------------------------------------------------------------------------
// dstx_pkg: shared types and constants for the slow-data transmit framer
// Opcodes, block kinds, frame byte constants and the modulo reduction helper.
// ----------------------------------------------------------------------------
package dstx_pkg;

  // Default configuration of the framer
  localparam int unsigned SYNC_INTERVAL_DEF  = 21;
  localparam int unsigned RESEND_PERIOD_DEF  = 16;
  localparam int unsigned MESSAGE_LENGTH_DEF = 20;
  localparam int unsigned HEADER_LENGTH_DEF  = 41;

  // Bytes per store row: one message piece or one header piece
  localparam int unsigned ROW_BYTES = 5;

  // Width of the modulo reduction datapath
  localparam int unsigned RED_W = 24;

  // Fixed byte values
  localparam logic [7:0] FILLER     = 8'h66;
  localparam logic [7:0] SYNC_BYTE0 = 8'h55;
  localparam logic [7:0] SYNC_BYTE1 = 8'h2D;
  localparam logic [7:0] SYNC_BYTE2 = 8'h16;
  localparam logic [7:0] SCRAMBLE0  = 8'h70;
  localparam logic [7:0] SCRAMBLE1  = 8'h4F;
  localparam logic [7:0] SCRAMBLE2  = 8'h93;
  localparam logic [7:0] TAG_SQUELCH = 8'hC2;
  localparam logic [7:0] TAG_MESSAGE = 8'h40;
  localparam logic [7:0] TAG_HEADER  = 8'h50;
  localparam logic [6:0] PIECE_NONE  = 7'd127;

  typedef enum logic [1:0] {
    OP_SYNC   = 2'd0,
    OP_DATA   = 2'd1,
    OP_WR_HDR = 2'd2,
    OP_WR_MSG = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    BLK_FILL    = 2'd0,
    BLK_SQUELCH = 2'd1,
    BLK_MESSAGE = 2'd2,
    BLK_HEADER  = 2'd3
  } blk_e;

  // Block build info handed from the control stage to the output stage
  typedef struct packed {
    logic       has_result;
    logic       is_sync;
    logic       odd;
    logic       use_blk;
    blk_e       kind;
    logic [2:0] hdr_n;
    logic [2:0] piece;
  } build_t;

  // Five restoring subtract steps of n << k, for k = k_hi down to k_hi - 4
  function automatic logic [RED_W-1:0] reduce_half(logic [RED_W-1:0] v,
                                                   logic [RED_W-1:0] n,
                                                   int unsigned k_hi);
    logic [RED_W-1:0] r;
    logic [RED_W-1:0] m;
    r = v;
    for (int j = 0; j < 5; j++) begin
      m = n << (k_hi - j);
      if (r >= m) begin
        r = r - m;
      end
    end
    return r;
  endfunction

endpackage

### hdl/dstar_slow_data_tx_framer_core.sv
// ----------------------------------------------------------------------------
// dstar_slow_data_tx_framer_core: slow-data transmit framer with scrambler
// Results pass through the stages below, then the output register.
// Throughput: one transaction per cycle while the skid stage is empty.
// Stages: fold, two modulo reduce stages, control plus row read, block build.
// Reset clears control state; store rows are undefined until written.
// ----------------------------------------------------------------------------
module dstar_slow_data_tx_framer_core #(
  parameter int unsigned SYNC_INTERVAL  = dstx_pkg::SYNC_INTERVAL_DEF,
  parameter int unsigned RESEND_PERIOD  = dstx_pkg::RESEND_PERIOD_DEF,
  parameter int unsigned MESSAGE_LENGTH = dstx_pkg::MESSAGE_LENGTH_DEF,
  parameter int unsigned HEADER_LENGTH  = dstx_pkg::HEADER_LENGTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        squelch_code_we_i,
  input  logic [6:0]  squelch_code_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] frame_count_i,
  input  logic [5:0]  write_index_i,
  input  logic [7:0]  write_data_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte0_o,
  output logic [7:0]  out_byte1_o,
  output logic [7:0]  out_byte2_o
);

  localparam int unsigned RED_W   = dstx_pkg::RED_W;
  localparam int unsigned RB      = dstx_pkg::ROW_BYTES;
  localparam int unsigned WHOLE   = RESEND_PERIOD * SYNC_INTERVAL;
  localparam int unsigned WHOLE_W = $clog2(WHOLE);
  localparam int unsigned SYNC_W  = $clog2(SYNC_INTERVAL);
  localparam int unsigned HROWS   = (HEADER_LENGTH + RB - 1) / RB;
  localparam int unsigned MROWS   = (MESSAGE_LENGTH + RB - 1) / RB;
  localparam int unsigned MPIECES = MESSAGE_LENGTH / RB;
  localparam int unsigned ROWS    = HROWS + MROWS;
  localparam int unsigned ROW_W   = $clog2(ROWS);
  localparam int unsigned HROW_W  = $clog2(HROWS + 1);
  localparam int unsigned HLAST   = HEADER_LENGTH - RB * (HROWS - 1);

  // Byte weights 2^(8k) mod N for folding the frame count
  localparam logic [RED_W-1:0] FW1 = RED_W'((64'd1 << 8) % 64'(WHOLE));
  localparam logic [RED_W-1:0] FW2 = RED_W'((64'd1 << 16) % 64'(WHOLE));
  localparam logic [RED_W-1:0] FW3 = RED_W'((64'd1 << 24) % 64'(WHOLE));
  localparam logic [RED_W-1:0] FS1 = RED_W'((64'd1 << 8) % 64'(SYNC_INTERVAL));
  localparam logic [RED_W-1:0] FS2 = RED_W'((64'd1 << 16) % 64'(SYNC_INTERVAL));
  localparam logic [RED_W-1:0] FS3 = RED_W'((64'd1 << 24) % 64'(SYNC_INTERVAL));

  // --------------------------------------------------------------------------
  // Handshake and pipeline enable
  // --------------------------------------------------------------------------
  logic skid_full_q;
  logic out_valid_q;
  logic en;
  logic take;

  assign en         = !skid_full_q;
  assign in_stall_o = skid_full_q;
  assign take       = out_valid_q && !out_stall_i;

  // --------------------------------------------------------------------------
  // Configuration: squelch code as enable plus BCD
  // --------------------------------------------------------------------------
  logic        sq_en_q;
  logic [7:0]  sq_bcd_q;
  logic [14:0] sq_prod;
  logic [3:0]  sq_tens;
  logic [3:0]  sq_ones;

  // divide by ten through a reciprocal, exact below 100
  assign sq_prod = 15'(squelch_code_i) * 15'd205;
  assign sq_tens = sq_prod[14:11];
  assign sq_ones = 4'(squelch_code_i - 7'(sq_tens) * 7'd10);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_en_q  <= 1'b0;
      sq_bcd_q <= 8'h00;
    end else if (squelch_code_we_i) begin
      sq_en_q  <= (squelch_code_i != 7'd0) && (squelch_code_i <= 7'd99);
      sq_bcd_q <= {sq_tens, sq_ones};
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: fold the frame count into weighted byte sums
  // --------------------------------------------------------------------------
  logic             p1_valid_q;
  dstx_pkg::op_e    p1_op_q;
  logic [5:0]       p1_idx_q;
  logic [7:0]       p1_data_q;
  logic [RED_W-1:0] p1_fw_q;
  logic [RED_W-1:0] p1_fs_q;
  logic [RED_W-1:0] fw_d;
  logic [RED_W-1:0] fs_d;

  assign fw_d = RED_W'(frame_count_i[7:0])
              + RED_W'(frame_count_i[15:8])  * FW1
              + RED_W'(frame_count_i[23:16]) * FW2
              + RED_W'(frame_count_i[31:24]) * FW3;
  assign fs_d = RED_W'(frame_count_i[7:0])
              + RED_W'(frame_count_i[15:8])  * FS1
              + RED_W'(frame_count_i[23:16]) * FS2
              + RED_W'(frame_count_i[31:24]) * FS3;

  // --------------------------------------------------------------------------
  // Stages 2 and 3: reduce the folded sums below their moduli
  // --------------------------------------------------------------------------
  logic               p2_valid_q;
  dstx_pkg::op_e      p2_op_q;
  logic [5:0]         p2_idx_q;
  logic [7:0]         p2_data_q;
  logic [RED_W-1:0]   p2_rw_q;
  logic [RED_W-1:0]   p2_rs_q;
  logic               p3_valid_q;
  dstx_pkg::op_e      p3_op_q;
  logic [5:0]         p3_idx_q;
  logic [7:0]         p3_data_q;
  logic [WHOLE_W-1:0] p3_rw_q;
  logic [SYNC_W-1:0]  p3_rs_q;
  logic [RED_W-1:0]   rw_d;
  logic [RED_W-1:0]   rs_d;

  assign rw_d = dstx_pkg::reduce_half(p2_rw_q, RED_W'(WHOLE), 4);
  assign rs_d = dstx_pkg::reduce_half(p2_rs_q, RED_W'(SYNC_INTERVAL), 4);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
      p3_valid_q <= 1'b0;
    end else if (en) begin
      p1_valid_q <= in_valid_i;
      p2_valid_q <= p1_valid_q;
      p3_valid_q <= p2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_op_q   <= dstx_pkg::op_e'(opcode_i);
      p1_idx_q  <= write_index_i;
      p1_data_q <= write_data_i;
      p1_fw_q   <= fw_d;
      p1_fs_q   <= fs_d;
      p2_op_q   <= p1_op_q;
      p2_idx_q  <= p1_idx_q;
      p2_data_q <= p1_data_q;
      p2_rw_q   <= dstx_pkg::reduce_half(p1_fw_q, RED_W'(WHOLE), 9);
      p2_rs_q   <= dstx_pkg::reduce_half(p1_fs_q, RED_W'(SYNC_INTERVAL), 9);
      p3_op_q   <= p2_op_q;
      p3_idx_q  <= p2_idx_q;
      p3_data_q <= p2_data_q;
      p3_rw_q   <= rw_d[WHOLE_W-1:0];
      p3_rs_q   <= rs_d[SYNC_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: block selection, store row read and store writes
  // --------------------------------------------------------------------------
  logic [6:0]        piece_q, piece_d;
  logic [HROW_W-1:0] hrow_q, hrow_d;
  logic              act_q, act_d;
  logic              use_q, use_d;
  logic              sq_hit;
  logic              rd_en;
  logic [ROW_W-1:0]  rd_row;
  logic              mem_we;
  logic [ROW_W-1:0]  wr_row;
  logic [2:0]        wr_lane;
  logic [9:0]        idx_prod;
  logic [3:0]        idx_row;
  dstx_pkg::build_t  build_d;

  // split the write index into row and lane, divide by five via reciprocal
  assign idx_prod = 10'(p3_idx_q) * 10'd13;
  assign idx_row  = idx_prod[9:6];
  assign wr_lane  = 3'(p3_idx_q - 6'(idx_row) * 6'd5);

  always_comb begin
    mem_we = 1'b0;
    wr_row = ROW_W'(idx_row);
    if (p3_valid_q && (p3_op_q == dstx_pkg::OP_WR_HDR) &&
        (7'(p3_idx_q) < 7'(HEADER_LENGTH))) begin
      mem_we = 1'b1;
    end
    if (p3_op_q == dstx_pkg::OP_WR_MSG) begin
      wr_row = ROW_W'(HROWS) + ROW_W'(idx_row);
      if (p3_valid_q && (7'(p3_idx_q) < 7'(MESSAGE_LENGTH))) begin
        mem_we = 1'b1;
      end
    end
  end

  // select the next block on odd frames
  always_comb begin
    piece_d = piece_q;
    hrow_d  = hrow_q;
    act_d   = act_q;
    use_d   = use_q;
    sq_hit  = 1'b0;
    rd_en   = 1'b0;
    rd_row  = '0;
    build_d.has_result = p3_valid_q &&
                         ((p3_op_q == dstx_pkg::OP_SYNC) || (p3_op_q == dstx_pkg::OP_DATA));
    build_d.is_sync    = (p3_op_q == dstx_pkg::OP_SYNC);
    build_d.odd        = p3_rs_q[0];
    build_d.kind       = dstx_pkg::BLK_FILL;
    build_d.hdr_n      = 3'd0;
    build_d.piece      = 3'd0;
    if (p3_valid_q && (p3_op_q == dstx_pkg::OP_DATA) && p3_rs_q[0]) begin
      use_d = 1'b0;
      // start of superframe: restart header, arm message on resend frames
      if (p3_rs_q == SYNC_W'(1)) begin
        piece_d = (p3_rw_q == WHOLE_W'(1)) ? 7'd0 : dstx_pkg::PIECE_NONE;
        hrow_d  = '0;
        act_d   = 1'b1;
        if (sq_en_q) begin
          sq_hit       = 1'b1;
          use_d        = 1'b1;
          build_d.kind = dstx_pkg::BLK_SQUELCH;
        end
      end
      if (!sq_hit) begin
        if (piece_d < 7'(MPIECES)) begin
          build_d.kind  = dstx_pkg::BLK_MESSAGE;
          build_d.piece = piece_d[2:0];
          rd_en         = 1'b1;
          rd_row        = ROW_W'(HROWS) + ROW_W'(piece_d);
          piece_d       = piece_d + 7'd1;
          use_d         = 1'b1;
          if (p3_rs_q > SYNC_W'(2)) begin
            act_d = 1'b0;
          end
        end else if (act_d) begin
          if (hrow_d < HROW_W'(HROWS)) begin
            build_d.kind  = dstx_pkg::BLK_HEADER;
            build_d.hdr_n = (hrow_d == HROW_W'(HROWS - 1)) ? 3'(HLAST) : 3'(RB);
            rd_en         = 1'b1;
            rd_row        = ROW_W'(hrow_d);
            hrow_d        = hrow_d + HROW_W'(1);
            use_d         = 1'b1;
          end else begin
            act_d = 1'b0;
          end
        end
      end
    end
    build_d.use_blk = use_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      piece_q <= dstx_pkg::PIECE_NONE;
      hrow_q  <= '0;
      act_q   <= 1'b0;
      use_q   <= 1'b0;
    end else if (en) begin
      piece_q <= piece_d;
      hrow_q  <= hrow_d;
      act_q   <= act_d;
      use_q   <= use_d;
    end
  end

  // Header rows followed by message rows, five byte lanes per row
  logic [RB-1:0][7:0] store_q [ROWS];
  logic [RB-1:0][7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en && mem_we) begin
      store_q[wr_row][wr_lane] <= p3_data_q;
    end
    if (en && rd_en) begin
      rdata_q <= store_q[rd_row];
    end
  end

  logic             p4_valid_q;
  dstx_pkg::build_t p4_build_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p4_valid_q <= 1'b0;
    end else if (en) begin
      p4_valid_q <= p3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p4_build_q <= build_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: build the block, scramble and keep the second half
  // --------------------------------------------------------------------------
  logic [5:0][7:0] blk;
  logic [2:0][7:0] src;
  logic [2:0][7:0] res;
  logic [2:0][7:0] ub_hi_q, ub_hi_d;
  logic            res_valid;

  always_comb begin
    blk = {6{dstx_pkg::FILLER}};
    case (p4_build_q.kind)
      dstx_pkg::BLK_SQUELCH: begin
        blk[0] = dstx_pkg::TAG_SQUELCH;
        blk[1] = sq_bcd_q;
        blk[2] = sq_bcd_q;
      end
      dstx_pkg::BLK_MESSAGE: begin
        blk[0] = dstx_pkg::TAG_MESSAGE | {5'd0, p4_build_q.piece};
        for (int i = 0; i < RB; i++) begin
          blk[i + 1] = rdata_q[i];
        end
      end
      dstx_pkg::BLK_HEADER: begin
        blk[0] = dstx_pkg::TAG_HEADER | {5'd0, p4_build_q.hdr_n};
        for (int i = 0; i < RB; i++) begin
          if (3'(i) < p4_build_q.hdr_n) begin
            blk[i + 1] = rdata_q[i];
          end
        end
      end
      default: begin
        blk = {6{dstx_pkg::FILLER}};
      end
    endcase
  end

  always_comb begin
    src     = {3{dstx_pkg::FILLER}};
    ub_hi_d = ub_hi_q;
    if (p4_build_q.use_blk) begin
      src = p4_build_q.odd ? blk[2:0] : ub_hi_q;
    end
    res[0] = src[0] ^ dstx_pkg::SCRAMBLE0;
    res[1] = src[1] ^ dstx_pkg::SCRAMBLE1;
    res[2] = src[2] ^ dstx_pkg::SCRAMBLE2;
    if (p4_build_q.is_sync) begin
      res[0] = dstx_pkg::SYNC_BYTE0;
      res[1] = dstx_pkg::SYNC_BYTE1;
      res[2] = dstx_pkg::SYNC_BYTE2;
    end
    // refill on sync, latch the second half when a new block goes out
    if (p4_valid_q && p4_build_q.has_result) begin
      if (p4_build_q.is_sync) begin
        ub_hi_d = {3{dstx_pkg::FILLER}};
      end else if (p4_build_q.odd && p4_build_q.use_blk) begin
        ub_hi_d = blk[5:3];
      end
    end
  end

  assign res_valid = p4_valid_q && p4_build_q.has_result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ub_hi_q <= {3{dstx_pkg::FILLER}};
    end else if (en) begin
      ub_hi_q <= ub_hi_d;
    end
  end

  // --------------------------------------------------------------------------
  // Output register with skid stage
  // --------------------------------------------------------------------------
  logic [2:0][7:0] out_b_q;
  logic [2:0][7:0] skid_b_q;
  logic            load_out;
  logic            load_skid;

  always_comb begin
    load_out  = 1'b0;
    load_skid = 1'b0;
    if (!skid_full_q && res_valid) begin
      if (!out_valid_q || take) begin
        load_out = 1'b1;
      end else begin
        load_skid = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_full_q <= 1'b0;
    end else if (skid_full_q) begin
      // drain the skid stage once the held result is taken
      if (take) begin
        skid_full_q <= 1'b0;
      end
    end else if (load_skid) begin
      skid_full_q <= 1'b1;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_full_q && take) begin
      out_b_q <= skid_b_q;
    end else if (load_out) begin
      out_b_q <= res;
    end
    if (load_skid) begin
      skid_b_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte0_o = out_b_q[0];
  assign out_byte1_o = out_b_q[1];
  assign out_byte2_o = out_b_q[2];

endmodule

### tb/tb_dstar_slow_data_tx_framer_core.sv
// ----------------------------------------------------------------------------
// tb_dstar_slow_data_tx_framer_core: self-checking bench for the tx framer
// Drives sync, data and store-write transactions with random gaps and output
// stalls, predicts the three bytes of every sync or scrambled data frame and
// compares each result field by field. Runs through several squelch settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_dstar_slow_data_tx_framer_core;
  import dstx_pkg::*;

  localparam int unsigned SYNC_LEN  = SYNC_INTERVAL_DEF;
  localparam int unsigned RESEND    = RESEND_PERIOD_DEF;
  localparam int unsigned MSG_LEN   = MESSAGE_LENGTH_DEF;
  localparam int unsigned HDR_LEN   = HEADER_LENGTH_DEF;
  localparam int unsigned DRAIN_CYC = 8;
  localparam int unsigned IDLE_LIMIT = 2000;

  typedef struct {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } slow_bytes_t;

  // Predict the slow-data bytes and hold the expected frames in order
  class slow_data_scoreboard;
    logic [6:0]  squelch;
    logic [7:0]  hdr_mem[HDR_LEN];
    logic [7:0]  msg_mem[MSG_LEN];
    logic [7:0]  blk[6];
    bit          blk_sel;
    int unsigned hdr_pos;
    bit          hdr_on;
    int unsigned piece;
    slow_bytes_t expected_bytes_q[$];
    int          errors;
    int          n_inputs;
    int          n_results;

    function new();
      squelch = '0;
      blk     = '{FILLER, FILLER, FILLER, FILLER, FILLER, FILLER};
      blk_sel = 1'b0;
      hdr_pos = 0;
      hdr_on  = 1'b0;
      piece   = PIECE_NONE;
      errors  = 0;
      n_inputs  = 0;
      n_results = 0;
    endfunction

    function int pending();
      return expected_bytes_q.size();
    endfunction

    // Select the six-byte block at an odd superframe position
    function void choose_block(logic [31:0] frame, int unsigned c);
      int unsigned sq;
      logic [7:0]  bcd;
      int unsigned left;
      int unsigned n;
      if (c == 1) begin
        sq      = squelch;
        piece   = ((frame % (RESEND * SYNC_LEN)) == 1) ? 0 : PIECE_NONE;
        hdr_pos = 0;
        hdr_on  = 1'b1;
        if (sq > 99) sq = 0;
        if (sq != 0) begin
          bcd     = 8'(((sq / 10) << 4) | (sq % 10));
          blk     = '{TAG_SQUELCH, bcd, bcd, FILLER, FILLER, FILLER};
          blk_sel = 1'b1;
          return;
        end
      end
      if (piece < MSG_LEN / ROW_BYTES) begin
        blk[0] = TAG_MESSAGE | 8'(piece);
        for (int i = 0; i < 5; i++) blk[1+i] = msg_mem[piece*5 + i];
        piece++;
        blk_sel = 1'b1;
        if (c > 2) hdr_on = 1'b0;
      end else if (hdr_on) begin
        left = (hdr_pos < HDR_LEN) ? HDR_LEN - hdr_pos : 0;
        if (left > 0) begin
          n      = (left > 5) ? 5 : left;
          blk[0] = TAG_HEADER | 8'(n);
          for (int i = 0; i < 5; i++) blk[1+i] = (i < n) ? hdr_mem[hdr_pos + i] : FILLER;
          hdr_pos += n;
          blk_sel = 1'b1;
        end else begin
          hdr_on = 1'b0;
        end
      end
    endfunction

    function logic [7:0] block_byte(int unsigned i);
      return blk_sel ? blk[i] : FILLER;
    endfunction

    // Update the model with an accepted transaction and queue its result
    function void note_input(op_e op, logic [31:0] frame, logic [5:0] idx, logic [7:0] data);
      int unsigned c;
      int unsigned off;
      slow_bytes_t e;
      n_inputs++;
      case (op)
        OP_WR_HDR: if (idx < HDR_LEN) hdr_mem[idx] = data;
        OP_WR_MSG: if (idx < MSG_LEN) msg_mem[idx] = data;
        OP_SYNC: begin
          blk = '{FILLER, FILLER, FILLER, FILLER, FILLER, FILLER};
          e.b0 = SYNC_BYTE0;
          e.b1 = SYNC_BYTE1;
          e.b2 = SYNC_BYTE2;
          expected_bytes_q.push_back(e);
        end
        default: begin
          c = frame % SYNC_LEN;
          if (c[0]) begin
            blk_sel = 1'b0;
            choose_block(frame, c);
            off = 0;
          end else begin
            off = 3;
          end
          e.b0 = block_byte(off) ^ SCRAMBLE0;
          e.b1 = block_byte(off + 1) ^ SCRAMBLE1;
          e.b2 = block_byte(off + 2) ^ SCRAMBLE2;
          expected_bytes_q.push_back(e);
        end
      endcase
    endfunction

    // Compare one delivered frame with the oldest expectation
    function void check_result(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
      slow_bytes_t e;
      n_results++;
      if (expected_bytes_q.size() == 0) begin
        $error("unexpected frame result %02h %02h %02h", b0, b1, b2);
        errors++;
        return;
      end
      e = expected_bytes_q.pop_front();
      if (b0 !== e.b0) begin
        $error("out_byte0: expected %02h, got %02h", e.b0, b0);
        errors++;
      end
      if (b1 !== e.b1) begin
        $error("out_byte1: expected %02h, got %02h", e.b1, b1);
        errors++;
      end
      if (b2 !== e.b2) begin
        $error("out_byte2: expected %02h, got %02h", e.b2, b2);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        squelch_code_we_i;
  logic [6:0]  squelch_code_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  opcode_i;
  logic [31:0] frame_count_i;
  logic [5:0]  write_index_i;
  logic [7:0]  write_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  out_byte0_o;
  logic [7:0]  out_byte1_o;
  logic [7:0]  out_byte2_o;

  slow_data_scoreboard sb = new();
  bit quiet;
  int n_settings;

  dstar_slow_data_tx_framer_core u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .squelch_code_we_i (squelch_code_we_i),
    .squelch_code_i    (squelch_code_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .opcode_i          (opcode_i),
    .frame_count_i     (frame_count_i),
    .write_index_i     (write_index_i),
    .write_data_i      (write_data_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_byte0_o       (out_byte0_o),
    .out_byte1_o       (out_byte1_o),
    .out_byte2_o       (out_byte2_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly short gaps, a few long ones, none in quiet phases
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Offer one transaction and hold it until accepted; returns at a falling edge
  task automatic send_item(op_e op, logic [31:0] frame, logic [5:0] idx, logic [7:0] data);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    opcode_i      <= op;
    frame_count_i <= frame;
    write_index_i <= idx;
    write_data_i  <= data;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(op, frame, idx, data);
    @(negedge clk_i);
  endtask

  task automatic send_frame(op_e op, logic [31:0] frame);
    send_item(op, frame, 6'($urandom), 8'($urandom));
  endtask

  // Wait until every frame is out, then let trailing writes settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_CYC) @(negedge clk_i);
  endtask

  task automatic write_squelch(logic [6:0] value);
    squelch_code_we_i <= 1'b1;
    squelch_code_i    <= value;
    @(negedge clk_i);
    squelch_code_we_i <= 1'b0;
    sb.squelch = value;
    n_settings++;
  endtask

  // Walk one superframe in order, with stray writes, syncs and dropped frames
  task automatic run_superframe();
    longint unsigned base;
    int unsigned     c0;
    int unsigned     r;
    op_e             op;
    base = longint'($urandom_range(0, 12782639)) * (RESEND * SYNC_LEN);
    if ($urandom_range(0, 99) >= 40) base += SYNC_LEN * $urandom_range(1, RESEND - 1);
    c0 = ($urandom_range(0, 9) == 0) ? $urandom_range(1, SYNC_LEN - 1) : 0;
    for (int unsigned c = c0; c < SYNC_LEN; c++) begin
      r = $urandom_range(0, 99);
      if (r < 4) send_item(OP_WR_HDR, $urandom, 6'($urandom), 8'($urandom));
      else if (r < 8) send_item(OP_WR_MSG, $urandom, 6'($urandom), 8'($urandom));
      else if (r < 11) send_frame(OP_SYNC, $urandom);
      if (r >= 97) continue;
      op = OP_DATA;
      if (c == 0 && r < 90) op = OP_SYNC;
      send_frame(op, 32'(base + c));
    end
  endtask

  task automatic send_noise();
    send_item(op_e'($urandom_range(0, 3)), $urandom, 6'($urandom), 8'($urandom));
  endtask

  // Random output stall runs
  initial begin
    int run;
    bit stalling;
    run = 0;
    stalling = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (quiet) begin
        run = 0;
        out_stall_i <= 1'b0;
      end else begin
        if (run == 0) begin
          stalling = ($urandom_range(0, 99) < 40);
          if (!stalling) run = $urandom_range(1, 8);
          else if ($urandom_range(0, 9) == 0) run = $urandom_range(10, 40);
          else run = $urandom_range(1, 3);
        end
        out_stall_i <= stalling;
        run--;
      end
    end
  end

  // Check each delivered frame
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        sb.check_result(out_byte0_o, out_byte1_o, out_byte2_o);
      end
    end
  end

  // End the run when nothing moves for too long
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    logic [6:0] settings[7];
    logic [7:0] data;
    rst_ni            = 1'b0;
    squelch_code_we_i = 1'b0;
    squelch_code_i    = '0;
    in_valid_i        = 1'b0;
    opcode_i          = OP_SYNC;
    frame_count_i     = '0;
    write_index_i     = '0;
    write_data_i      = '0;
    quiet             = 1'b0;
    n_settings        = 0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Even frames before any odd frame, an odd frame with nothing to send, sync
    send_frame(OP_DATA, 32'd0);
    send_frame(OP_DATA, 32'd2);
    send_frame(OP_DATA, 32'hFFFF_FFFF);
    send_frame(OP_SYNC, 32'd0);

    // Load both stores fully so no unwritten byte ever goes into a block
    for (int i = 0; i < HDR_LEN; i++) begin
      data = (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom);
      send_item(OP_WR_HDR, $urandom, 6'(i), data);
    end
    for (int i = 0; i < MSG_LEN; i++) begin
      data = (i == 0) ? 8'hFF : (i == 1) ? 8'h00 : 8'($urandom);
      send_item(OP_WR_MSG, $urandom, 6'(i), data);
    end

    // Out-of-range writes must be dropped
    send_item(OP_WR_HDR, 32'd0, 6'(HDR_LEN), 8'hA5);
    send_item(OP_WR_HDR, 32'd0, 6'd63, 8'h5A);
    send_item(OP_WR_MSG, 32'd0, 6'(MSG_LEN), 8'hA5);
    send_item(OP_WR_MSG, 32'd0, 6'd63, 8'h5A);

    // Message superframe start: all four pieces, then filler
    for (int unsigned f = 1; f <= 10; f++) send_frame(OP_DATA, 32'(f));

    // Random phases over several squelch settings
    settings = '{7'd99, 7'd1, 7'd127, 7'd100, 7'($urandom_range(2, 98)), 7'd0,
                 7'($urandom_range(0, 127))};
    for (int p = 0; p < 7; p++) begin
      drain();
      write_squelch(settings[p]);
      quiet = (p == 2);
      for (int k = 0; k < 4; k++) run_superframe();
      repeat (12) send_noise();
    end
    quiet = 1'b0;
    drain();

    $display("Checked %0d frame results from %0d transactions over %0d squelch settings.",
             sb.n_results, sb.n_inputs, n_settings);
    $display("Covered message, header and squelch blocks, syncs, noise and dropped frames.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
